/* hdl/temon_pkg.sv */
`default_nettype none

package temon_pkg;

    localparam int CMD_W    = 2;
    localparam int TASK_W   = 3;
    localparam int TIMER_W  = 16;
    localparam int STAMP_W  = 32;
    localparam int LOAD_W   = 8;
    localparam int PERIOD_W = 16;

    localparam int NUM_TASKS_DEF = 8;
    localparam int Q_DEPTH       = 2;

    localparam logic [STAMP_W-1:0]  LOAD_DIVISOR = 32'd20000000;
    // 20000000 is 78125 << 8; for any 24-bit x, x / 78125 equals
    // (x * ceil(2^41 / 78125)) >> 41
    localparam int                    LOAD_PRE_SH = 8;
    localparam int                    LOAD_RCP_SH = 41;
    localparam int                    LOAD_RCP_W  = 25;
    localparam logic [LOAD_RCP_W-1:0] LOAD_RCP    = 25'd28147498;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd305;

    typedef enum logic [CMD_W-1:0] {
        CMD_START   = 2'd0,
        CMD_STOP    = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_ANALYZE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WALK
    } t_state;

    typedef struct packed {
        t_cmd                cmd;
        logic [TASK_W-1:0]   task_idx;
        logic [TIMER_W-1:0]  timer_value;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_push;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_head;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

/* hdl/task_execution_time_monitor.sv */
// Task execution time monitor. Start and stop requests stamp a task with a 32-bit wrapping
// time built from the 16-bit timer and the overflow tick count; an analyze request reports
// one result per task in index order (last_of_run on the final one), folding each newly
// measured duration into the task's last and period-maximum figures and the busy total.
// The input side registers and classifies each request and hands it through a two-entry
// queue to a sequencer, so input and output stall independently. In the sequencer start,
// stop and tick requests are handled from the idle state; an analyze pass walks every task
// with one result a cycle while the output is not stalled, preceded by a step in which a
// reciprocal multiplication forms the load figure when the measurement period has ended.
// The per-task stores sit in registered-read memories walked one entry per result; their
// reset contents are supplied by per-entry valid flags, so no clearing pass follows reset.
`default_nettype none

module task_execution_time_monitor import temon_pkg::*; #(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [PERIOD_W-1:0]  i_cfg_wr_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire logic [TASK_W-1:0]    i_task_index,
    input  wire logic [TIMER_W-1:0]   i_timer_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [TASK_W-1:0]         o_report_task,
    output logic [STAMP_W-1:0]        o_last_duration,
    output logic [STAMP_W-1:0]        o_max_duration,
    output logic [LOAD_W-1:0]         o_load_value,
    output logic                      o_last_of_run
);

    localparam logic [TASK_W-1:0] LAST_REPORT = TASK_W'(NUM_TASKS - 1);

    t_push w_push;
    t_head w_head;
    logic  w_q_full;
    logic  w_pop;

    temon_front #(.NUM_TASKS(NUM_TASKS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_task_index  (i_task_index),
        .i_timer_value (i_timer_value),
        .o_push        (w_push),
        .i_q_full      (w_q_full)
    );

    temon_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    temon_back #(.NUM_TASKS(NUM_TASKS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_report_task   (o_report_task),
        .o_last_duration (o_last_duration),
        .o_max_duration  (o_max_duration),
        .o_load_value    (o_load_value),
        .o_last_of_run   (o_last_of_run)
    );

    // the input side only holds back when the queue has no room
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_q_full)
        else $error("input stalled while queue has room");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("sequencer popped an empty queue");

    a_last_is_final_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_run) |-> (o_report_task == LAST_REPORT))
        else $error("last_of_run flagged on a task other than the final one");

endmodule

`default_nettype wire

/* hdl/temon_ram.sv */
`default_nettype none

module temon_ram import temon_pkg::*; #(
    parameter int WIDTH = STAMP_W,
    parameter int DEPTH = NUM_TASKS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [idx_w(DEPTH)-1:0]   i_wr_addr,
    input  wire logic [WIDTH-1:0]          i_wr_data,
    input  wire logic [idx_w(DEPTH)-1:0]   i_rd_addr,
    output logic      [WIDTH-1:0]          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hdl/temon_front.sv */
`default_nettype none

module temon_front import temon_pkg::*; #(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [CMD_W-1:0]    i_cmd,
    input  wire logic [TASK_W-1:0]   i_task_index,
    input  wire logic [TIMER_W-1:0]  i_timer_value,
    output t_push                    o_push,
    input  wire logic                i_q_full
);

    logic r_valid, n_valid;
    t_req r_req;
    logic r_keep;
    logic w_in_range, w_keep, w_leave, w_accept;

    assign w_in_range = 32'(i_task_index) < NUM_TASKS;
    // stamps for a task beyond the table are dropped here
    assign w_keep     = !(i_cmd inside {CMD_START, CMD_STOP}) || w_in_range;
    assign w_leave    = r_valid && (!r_keep || !i_q_full);
    assign o_in_stall = r_valid && !w_leave;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (w_leave) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.cmd         <= t_cmd'(i_cmd);
            r_req.task_idx    <= i_task_index;
            r_req.timer_value <= i_timer_value;
            r_keep            <= w_keep;
        end
    end

    assign o_push.valid = r_valid && r_keep && !i_q_full;
    assign o_push.req   = r_req;

endmodule

`default_nettype wire

/* hdl/temon_queue.sv */
`default_nettype none

module temon_queue import temon_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_push  i_push,
    output logic        o_full,
    output t_head       o_head,
    input  wire logic   i_pop
);

    localparam int QAW = idx_w(Q_DEPTH);
    localparam int QCW = idx_w(Q_DEPTH + 1);
    localparam logic [QAW-1:0] LAST_PTR = QAW'(Q_DEPTH - 1);

    t_req            r_mem [Q_DEPTH];
    logic [QAW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0]  r_count;
    logic            w_do_push, w_do_pop;

    assign o_full      = (r_count == QCW'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.req   = r_mem[r_rd_ptr];
    assign w_do_push   = i_push.valid && !o_full;
    assign w_do_pop    = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push.req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + QAW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + QAW'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/temon_back.sv */
`default_nettype none

module temon_back import temon_pkg::*; #(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [PERIOD_W-1:0]  i_cfg_wr_data,
    input  wire t_head                i_head,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [TASK_W-1:0]         o_report_task,
    output logic [STAMP_W-1:0]        o_last_duration,
    output logic [STAMP_W-1:0]        o_max_duration,
    output logic [LOAD_W-1:0]         o_load_value,
    output logic                      o_last_of_run
);

    localparam int TW  = idx_w(NUM_TASKS);
    localparam int BHW = STAMP_W - LOAD_PRE_SH;
    localparam int PW  = BHW + LOAD_RCP_W;
    localparam logic [TW-1:0] LAST_IDX = TW'(NUM_TASKS - 1);

    t_state                r_state, n_state;
    logic [TW-1:0]         r_walk, n_walk;
    logic [STAMP_W-1:0]    r_ovf, n_ovf;
    logic [STAMP_W-1:0]    r_busy, n_busy;
    logic [LOAD_W-1:0]     r_load, n_load;
    logic [PERIOD_W-1:0]   r_period;
    logic [NUM_TASKS-1:0]  r_mark, n_mark;
    logic [NUM_TASKS-1:0]  r_start_vld, n_start_vld;
    logic [NUM_TASKS-1:0]  r_dur_vld, n_dur_vld;
    logic [NUM_TASKS-1:0]  r_max_vld, n_max_vld;
    logic                  r_out_valid, n_out_valid;

    logic [TASK_W-1:0]     r_out_task, n_out_task;
    logic [STAMP_W-1:0]    r_out_dur, n_out_dur;
    logic [STAMP_W-1:0]    r_out_max, n_out_max;
    logic [LOAD_W-1:0]     r_out_load, n_out_load;
    logic                  r_out_last, n_out_last;

    logic [TW-1:0]         w_head_idx;
    logic [STAMP_W-1:0]    w_time;
    logic                  w_start_we, w_stop_we, w_dm_we;
    logic [STAMP_W-1:0]    w_start_q, w_stop_q;
    logic [2*STAMP_W-1:0]  w_dm_q;
    logic [STAMP_W-1:0]    w_start, w_d, w_cur_dur, w_cur_max, w_new_dur, w_new_max;
    logic                  w_commit, w_has;
    logic [BHW-1:0]        w_busy_hi;
    logic [PW-1:0]         w_load_prod;
    logic [LOAD_W-1:0]     w_load;

    assign w_head_idx = TW'(i_head.req.task_idx);
    // overflow_count * 0xFFFF is (count << 16) - count, wrapping at 32 bits
    assign w_time = {r_ovf[STAMP_W-TIMER_W-1:0], {TIMER_W{1'b0}}} - r_ovf
                    + STAMP_W'(i_head.req.timer_value);

    // start, duration and maximum entries never written read as zero
    assign w_has     = r_mark[r_walk];
    assign w_start   = r_start_vld[r_walk] ? w_start_q : '0;
    assign w_cur_dur = r_dur_vld[r_walk] ? w_dm_q[2*STAMP_W-1:STAMP_W] : '0;
    assign w_cur_max = r_max_vld[r_walk] ? w_dm_q[STAMP_W-1:0] : '0;
    assign w_d       = w_stop_q - w_start;
    assign w_new_dur = w_has ? w_d : w_cur_dur;
    assign w_new_max = (w_has && (w_d > w_cur_max)) ? w_d : w_cur_max;
    assign w_commit  = !r_out_valid || !i_out_stall;

    // busy total / 20000000 by reciprocal multiplication of the upper bits
    assign w_busy_hi   = r_busy[STAMP_W-1:LOAD_PRE_SH];
    assign w_load_prod = PW'(w_busy_hi) * PW'(LOAD_RCP);
    assign w_load      = w_load_prod[LOAD_RCP_SH +: LOAD_W];

    temon_ram #(.WIDTH(STAMP_W), .DEPTH(NUM_TASKS)) u_start_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_start_we),
        .i_wr_addr (w_head_idx),
        .i_wr_data (w_time),
        .i_rd_addr (n_walk),
        .o_rd_data (w_start_q)
    );

    temon_ram #(.WIDTH(STAMP_W), .DEPTH(NUM_TASKS)) u_stop_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_stop_we),
        .i_wr_addr (w_head_idx),
        .i_wr_data (w_time),
        .i_rd_addr (n_walk),
        .o_rd_data (w_stop_q)
    );

    // last duration in the upper half, period maximum in the lower half
    temon_ram #(.WIDTH(2 * STAMP_W), .DEPTH(NUM_TASKS)) u_figure_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_dm_we),
        .i_wr_addr (r_walk),
        .i_wr_data ({w_new_dur, w_new_max}),
        .i_rd_addr (n_walk),
        .o_rd_data (w_dm_q)
    );

    always_comb begin
        n_state     = r_state;
        n_walk      = r_walk;
        n_ovf       = r_ovf;
        n_busy      = r_busy;
        n_load      = r_load;
        n_mark      = r_mark;
        n_start_vld = r_start_vld;
        n_dur_vld   = r_dur_vld;
        n_max_vld   = r_max_vld;
        n_out_valid = r_out_valid;
        n_out_task  = r_out_task;
        n_out_dur   = r_out_dur;
        n_out_max   = r_out_max;
        n_out_load  = r_out_load;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        w_start_we  = 1'b0;
        w_stop_we   = 1'b0;
        w_dm_we     = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    case (i_head.req.cmd)
                        CMD_START: begin
                            w_start_we              = 1'b1;
                            n_start_vld[w_head_idx] = 1'b1;
                            n_mark[w_head_idx]      = 1'b0;
                        end
                        CMD_STOP: begin
                            w_stop_we          = 1'b1;
                            n_mark[w_head_idx] = 1'b1;
                        end
                        CMD_TICK: begin
                            n_ovf = r_ovf + STAMP_W'(1);
                        end
                        CMD_ANALYZE: begin
                            if (r_ovf > STAMP_W'(r_period)) begin
                                n_state = ST_DIV;
                            end else begin
                                n_state = ST_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // period end: take the load figure and clear the period totals
            ST_DIV: begin
                n_load    = w_load;
                n_busy    = '0;
                n_ovf     = '0;
                n_max_vld = '0;
                n_state   = ST_WALK;
            end

            ST_WALK: begin
                if (w_commit) begin
                    if (w_has) begin
                        w_dm_we           = 1'b1;
                        n_dur_vld[r_walk] = 1'b1;
                        n_max_vld[r_walk] = 1'b1;
                        n_mark[r_walk]    = 1'b0;
                        n_busy            = r_busy + w_d;
                    end
                    n_out_valid = 1'b1;
                    n_out_task  = TASK_W'(r_walk);
                    n_out_dur   = w_new_dur;
                    n_out_max   = w_new_max;
                    n_out_load  = r_load;
                    n_out_last  = (r_walk == LAST_IDX);
                    if (r_walk == LAST_IDX) begin
                        n_walk  = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_walk = r_walk + TW'(1);
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_walk      <= '0;
            r_ovf       <= '0;
            r_busy      <= '0;
            r_load      <= '0;
            r_mark      <= '0;
            r_start_vld <= '0;
            r_dur_vld   <= '0;
            r_max_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_walk      <= n_walk;
            r_ovf       <= n_ovf;
            r_busy      <= n_busy;
            r_load      <= n_load;
            r_mark      <= n_mark;
            r_start_vld <= n_start_vld;
            r_dur_vld   <= n_dur_vld;
            r_max_vld   <= n_max_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_period <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_task <= n_out_task;
        r_out_dur  <= n_out_dur;
        r_out_max  <= n_out_max;
        r_out_load <= n_out_load;
        r_out_last <= n_out_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_report_task   = r_out_task;
    assign o_last_duration = r_out_dur;
    assign o_max_duration  = r_out_max;
    assign o_load_value    = r_out_load;
    assign o_last_of_run   = r_out_last;

endmodule

`default_nettype wire
